// ----- src/hsb2rgb_pkg.sv -----
// Shared constants and types for the HSB to RGB converter.
`default_nettype none

package hsb2rgb_pkg;

  // Fraction bits of hue, saturation and brightness; 1.0 is 2**FRAC_BITS.
  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = FRAC_BITS;
  localparam int SAT_W     = FRAC_BITS + 1;
  localparam int H6_W      = FRAC_BITS + 3;
  localparam int PROD_W    = 2 * FRAC_BITS + 1;
  localparam int ROUND_W   = PROD_W + 8;
  localparam int ALPHA_W   = 8;
  localparam int COLOR_W   = 32;

  localparam logic [SAT_W-1:0]   ONE        = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 8'hFF;
  localparam logic [ROUND_W-1:0] ROUND_HALF = ROUND_W'(1) << (2 * FRAC_BITS - 1);

  // The six hue sectors, named by the primaries they run between.
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// ----- src/hsb_to_rgb_converter_unit.sv -----
// Top level of the pipelined HSB to RGB converter.
`default_nettype none

// The converter takes one hue, saturation and brightness item per clock and
// returns one packed RGBA word per item, in the order the items came in. busy
// is low whenever the block is out of reset, so an item can be issued on every
// cycle with start. Each result appears for exactly one cycle with out_valid
// high; the receiver must take it then, since nothing can hold it back.
// Each item passes through the stage chain: hue sector split, the two
// saturation-times-fraction multipliers, the three brightness multipliers,
// the per-sector channel select, and the final scaling by 255 with round
// half up. Saturation and brightness above 1.0 are clamped to 1.0. The alpha
// byte comes from a register written through the cfg_ port; it resets to 255
// and should only be changed while no item is in flight, because it is placed
// into the result as it leaves the block.
module hsb_to_rgb_converter_unit
  import hsb2rgb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input item channel.
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [HUE_W-1:0]   in_hue_fraction,
  input  wire logic [SAT_W-1:0]   in_saturation,
  input  wire logic [SAT_W-1:0]   in_brightness,
  // Result channel.
  output logic                    out_valid,
  output logic [COLOR_W-1:0]      out_packed_color,
  // Alpha register write channel.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [ALPHA_W-1:0] cfg_data
);

  // Scales a Q.(2*FRAC_BITS) channel value by 255, rounds half up and
  // clamps to a byte.
  function automatic logic [7:0] to_byte(input logic [PROD_W-1:0] v);
    logic [ROUND_W-1:0] scaled;
    logic [8:0]         whole;
    scaled = {v, 8'b0} - {8'b0, v} + ROUND_HALF;
    whole  = scaled[ROUND_W-1:2*FRAC_BITS];
    return (whole > 9'd255) ? 8'hFF : whole[7:0];
  endfunction

  logic accept;
  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start & ~busy;

  // Alpha register.
  logic [ALPHA_W-1:0] alpha_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      alpha_r <= cfg_data;
    end
  end

  // Valid bits travel alongside the data through every stage.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Stage 1: multiply the hue by six, split it into a sector and a fraction
  // within the sector, and clamp saturation and brightness to 1.0.
  logic [H6_W-1:0]      h6;
  logic [SAT_W-1:0]     s_sat, b_sat;
  sector_t              sec1_r;
  logic [FRAC_BITS-1:0] f1_r;
  logic [SAT_W-1:0]     s1_r, b1_r;

  assign h6    = ({3'b000, in_hue_fraction} << 2) + ({3'b000, in_hue_fraction} << 1);
  assign s_sat = (in_saturation > ONE) ? ONE : in_saturation;
  assign b_sat = (in_brightness > ONE) ? ONE : in_brightness;

  always_ff @(posedge clk) begin
    sec1_r <= sector_t'(h6[H6_W-1:FRAC_BITS]);
    f1_r   <= h6[FRAC_BITS-1:0];
    s1_r   <= s_sat;
    b1_r   <= b_sat;
  end

  // Stage 2: S*f and S*(1-f), truncated back to FRAC_BITS fraction bits.
  logic [PROD_W-1:0] sf_full, sg_full;
  logic [SAT_W-1:0]  one_minus_f;
  sector_t           sec2_r;
  logic [SAT_W-1:0]  sf2_r, sg2_r, oms2_r, b2_r;

  assign one_minus_f = ONE - {1'b0, f1_r};
  assign sf_full     = PROD_W'(s1_r) * PROD_W'(f1_r);
  assign sg_full     = PROD_W'(s1_r) * PROD_W'(one_minus_f);

  always_ff @(posedge clk) begin
    sec2_r <= sec1_r;
    sf2_r  <= sf_full[2*FRAC_BITS:FRAC_BITS];
    sg2_r  <= sg_full[2*FRAC_BITS:FRAC_BITS];
    oms2_r <= ONE - s1_r;
    b2_r   <= b1_r;
  end

  // Stage 3: p, q and t at full precision; brightness widened to match.
  logic [SAT_W-1:0]  one_minus_sf, one_minus_sg;
  sector_t           sec3_r;
  logic [PROD_W-1:0] p3_r, q3_r, t3_r, vb3_r;

  assign one_minus_sf = ONE - sf2_r;
  assign one_minus_sg = ONE - sg2_r;

  always_ff @(posedge clk) begin
    sec3_r <= sec2_r;
    p3_r   <= PROD_W'(b2_r) * PROD_W'(oms2_r);
    q3_r   <= PROD_W'(b2_r) * PROD_W'(one_minus_sf);
    t3_r   <= PROD_W'(b2_r) * PROD_W'(one_minus_sg);
    vb3_r  <= {b2_r, {FRAC_BITS{1'b0}}};
  end

  // Stage 4: route p, q, t and brightness to the channels by sector.
  logic [PROD_W-1:0] rv_nxt, gv_nxt, bv_nxt;
  logic [PROD_W-1:0] rv4_r, gv4_r, bv4_r;

  always_comb begin
    case (sec3_r)
      SEC_R_TO_Y: begin
        rv_nxt = vb3_r; gv_nxt = t3_r;  bv_nxt = p3_r;
      end
      SEC_Y_TO_G: begin
        rv_nxt = q3_r;  gv_nxt = vb3_r; bv_nxt = p3_r;
      end
      SEC_G_TO_C: begin
        rv_nxt = p3_r;  gv_nxt = vb3_r; bv_nxt = t3_r;
      end
      SEC_C_TO_B: begin
        rv_nxt = p3_r;  gv_nxt = q3_r;  bv_nxt = vb3_r;
      end
      SEC_B_TO_M: begin
        rv_nxt = t3_r;  gv_nxt = p3_r;  bv_nxt = vb3_r;
      end
      default: begin
        rv_nxt = vb3_r; gv_nxt = p3_r;  bv_nxt = q3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rv4_r <= rv_nxt;
    gv4_r <= gv_nxt;
    bv4_r <= bv_nxt;
  end

  // Stage 5: scale each channel to a byte and hold the result for one cycle.
  logic [23:0] rgb_r;
  always_ff @(posedge clk) begin
    rgb_r <= {to_byte(rv4_r), to_byte(gv4_r), to_byte(bv4_r)};
  end

  assign out_valid        = out_valid_r;
  assign out_packed_color = {rgb_r, alpha_r};

  // Every accepted item leaves the block as a result.
  a_item_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted item did not produce a result after five cycles");

  // No result without a matching accepted item.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result strobe without a matching accepted item");

  // Zero saturation at full brightness is white: every channel byte is 255,
  // whatever the hue.
  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_brightness >= ONE && in_saturation == '0) |->
      ##5 (out_packed_color[31:8] == 24'hFFFFFF))
    else $error("zero saturation at full brightness did not give white");

endmodule

`default_nettype wire

// ----- bench/hsb_to_rgb_converter_unit_tb.sv -----
// Self-checking testbench for the HSB to RGB converter: bursty items, alpha writes, color checks.
`timescale 1ns / 100ps

module hsb_to_rgb_converter_unit_tb
  import hsb2rgb_pkg::*;
();

  // Cycles waited after the last expected color has come back, to catch any
  // stray result still in flight.
  localparam int DRAIN_CYCLES = 8;
  // The longest quiet stretch in a correct run is a sender gap or a drain wait;
  // this limit is far beyond either.
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 105;

  // One item as the sender presents it.
  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SAT_W-1:0] bri;
  } hsb_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [HUE_W-1:0]   in_hue_fraction = '0;
  logic [SAT_W-1:0]   in_saturation = '0;
  logic [SAT_W-1:0]   in_brightness = '0;
  logic               out_valid;
  logic [COLOR_W-1:0] out_packed_color;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ALPHA_W-1:0] cfg_data = '0;

  // Items waiting to be issued, and the colors predicted for issued items.
  hsb_item_t          hsb_queue[$];
  logic [COLOR_W-1:0] rgba_expected[$];

  // The testbench's own copy of the alpha register.
  logic [ALPHA_W-1:0] alpha_shadow = ALPHA_RST;

  int mismatches     = 0;
  int items_issued   = 0;
  int colors_checked = 0;
  int alpha_writes   = 0;
  int gray_items     = 0;
  int clamped_items  = 0;
  int quiet_cycles   = 0;

  // Sender burst state: how many items remain in the burst and how many idle
  // cycles to insert before the next one.
  int burst_left = 4;
  int gap_left   = 0;

  logic [COLOR_W-1:0] want_color;

  hsb_to_rgb_converter_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_hue_fraction  (in_hue_fraction),
    .in_saturation    (in_saturation),
    .in_brightness    (in_brightness),
    .out_valid        (out_valid),
    .out_packed_color (out_packed_color),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Scales a Q.32 channel value by 255, rounds half up and clips to a byte.
  function automatic logic [7:0] scale_channel(input logic [63:0] v);
    logic [63:0] r;
    r = (v * 64'd255 + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    if (r > 64'd255) begin
      r = 64'd255;
    end
    return r[7:0];
  endfunction

  // Computes the packed RGBA word that one item should produce. The hue is
  // split into a sector and a fraction f within it; p, q and t are the three
  // off-peak channel levels, held exactly at twice the fraction width.
  function automatic logic [COLOR_W-1:0] predict_rgba(input hsb_item_t it,
                                                      input logic [ALPHA_W-1:0] alpha);
    logic [63:0] unity, s, b, h6, f, sf, sg, vb, p, q, t, rv, gv, bv;
    sector_t     sec;
    unity = 64'd1 << FRAC_BITS;
    // Saturation and brightness above 1.0 are clamped to 1.0.
    s  = (64'(it.sat) > unity) ? unity : 64'(it.sat);
    b  = (64'(it.bri) > unity) ? unity : 64'(it.bri);
    h6 = 64'(it.hue) * 64'd6;
    sec = sector_t'(h6[H6_W-1:FRAC_BITS]);
    f  = h6 & (unity - 64'd1);
    sf = (s * f) >> FRAC_BITS;
    sg = (s * (unity - f)) >> FRAC_BITS;
    vb = b << FRAC_BITS;
    p  = b * (unity - s);
    q  = b * (unity - sf);
    t  = b * (unity - sg);
    case (sec)
      SEC_R_TO_Y: begin rv = vb; gv = t;  bv = p;  end
      SEC_Y_TO_G: begin rv = q;  gv = vb; bv = p;  end
      SEC_G_TO_C: begin rv = p;  gv = vb; bv = t;  end
      SEC_C_TO_B: begin rv = p;  gv = q;  bv = vb; end
      SEC_B_TO_M: begin rv = t;  gv = p;  bv = vb; end
      default: begin rv = vb; gv = p;  bv = q;  end
    endcase
    return {scale_channel(rv), scale_channel(gv), scale_channel(bv), alpha};
  endfunction

  // Picks a saturation or brightness level. Most are in range, some sit on
  // zero or exactly 1.0, and some use all 17 bits so that the clamp is hit.
  function automatic logic [SAT_W-1:0] random_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE;
      2, 3: return SAT_W'($urandom);
      default: return SAT_W'($urandom_range(0, int'(ONE)));
    endcase
  endfunction

  task automatic add_item(input logic [HUE_W-1:0] h, input logic [SAT_W-1:0] s,
                          input logic [SAT_W-1:0] b);
    hsb_item_t it;
    it.hue = h;
    it.sat = s;
    it.bri = b;
    hsb_queue.push_back(it);
  endtask

  // Writes the alpha register and waits for the write to be taken. cfg_ready
  // is read right after the edge, so it holds the value the block had there.
  task automatic write_alpha(input logic [ALPHA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    cfg_valid    <= 1'b0;
    alpha_shadow  = value;
    alpha_writes++;
  endtask

  // Lets the sender run dry and waits until every predicted color has come
  // back, then waits out DRAIN_CYCLES in case anything is still in the pipeline.
  task automatic wait_drained();
    while (hsb_queue.size() != 0 || rgba_expected.size() != 0 || start) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender. An item counts as taken at an edge where start is high and busy
  // is low; its color is predicted right then, with the alpha in force. The
  // sender works in bursts of random length separated by random gaps, and
  // some bursts run back to back with no gap at all.
  always @(posedge clk) begin
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (hsb_queue[0].sat == '0) begin
          gray_items++;
        end
        if (hsb_queue[0].sat > ONE || hsb_queue[0].bri > ONE) begin
          clamped_items++;
        end
        rgba_expected.push_back(predict_rgba(hsb_queue.pop_front(), alpha_shadow));
        items_issued++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        go = 1'b0;
      end else begin
        go = (hsb_queue.size() != 0);
      end
      if (go) begin
        in_hue_fraction <= hsb_queue[0].hue;
        in_saturation   <= hsb_queue[0].sat;
        in_brightness   <= hsb_queue[0].bri;
      end
      start <= go;
    end
  end

  // Receiver. It cannot hold results off, so it takes every color the cycle
  // it appears and compares it with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rgba_expected.size() == 0) begin
        report_mismatch($sformatf("color %08h arrived with none expected",
                                  out_packed_color));
      end else begin
        want_color = rgba_expected.pop_front();
        colors_checked++;
        if (out_packed_color !== want_color) begin
          report_mismatch($sformatf("packed_color got %08h want %08h",
                                    out_packed_color, want_color));
        end
      end
    end
  end

  // Watchdog. It counts cycles in which no item, color or alpha write moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout after %0d quiet cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus. Each phase is filled while the block is idle, then drained
  // completely, so the alpha register only changes with nothing in flight.
  initial begin
    logic [ALPHA_W-1:0] phase_alpha[6];
    logic [HUE_W-1:0]   h;
    phase_alpha[0] = 8'h00;
    phase_alpha[1] = 8'hFF;
    phase_alpha[2] = 8'h5A;
    phase_alpha[3] = 8'hA5;
    phase_alpha[4] = ALPHA_W'($urandom);
    phase_alpha[5] = ALPHA_W'($urandom);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset alpha. Gray with zero saturation, black,
    // full white, the primaries, every sector edge, the top of the hue range,
    // and saturation or brightness above 1.0 that must be clamped.
    add_item(16'h0000, '0, '0);
    add_item(16'h0000, '0, ONE);
    add_item(16'h8000, '0, 17'h08000);
    add_item(16'h1234, '0, 17'h1FFFF);
    add_item(16'd50000, ONE, '0);
    add_item(16'h0000, ONE, ONE);
    add_item(16'd10922, ONE, ONE);
    add_item(16'd10923, ONE, ONE);
    add_item(16'd21845, ONE, ONE);
    add_item(16'd21846, ONE, ONE);
    add_item(16'd32768, ONE, ONE);
    add_item(16'd43690, ONE, ONE);
    add_item(16'd43691, ONE, ONE);
    add_item(16'd54613, ONE, ONE);
    add_item(16'd54614, ONE, ONE);
    add_item(16'hFFFF, ONE, ONE);
    add_item(16'd5461, 17'h08000, 17'h0C000);
    add_item(16'd12345, 17'h1FFFF, 17'h1FFFF);
    add_item(16'd40000, ONE + 17'd1, ONE + 17'd1);
    add_item(16'd30000, 17'h1FFFF, 17'd1000);
    add_item(16'h0001, 17'd1, 17'd1);
    add_item(16'hFFFF, 17'h0FFFF, 17'h0FFFF);
    wait_drained();

    // Random phases, each under its own alpha setting. Now and then the hue
    // is placed within a few steps of a sector edge.
    foreach (phase_alpha[i]) begin
      write_alpha(phase_alpha[i]);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          h = HUE_W'(($urandom_range(0, 5) * 65536 + 5) / 6 + $urandom_range(0, 6) - 3);
        end else begin
          h = HUE_W'($urandom);
        end
        add_item(h, random_level(), random_level());
      end
      wait_drained();
    end

    $display("Covered %0d items (%0d gray, %0d clamped) and %0d colors checked,",
             items_issued, gray_items, clamped_items, colors_checked);
    $display("over %0d alpha settings including 0x00 and 0xFF; %0d mismatches.",
             alpha_writes + 1, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
